[src/dqds_pkg.sv]
// Package for the dual quadrature decoder with speed estimate.
// Holds widths, reset values, register indexes, the step table and lane structs.
// No dependencies.
package dqds_pkg;

  // Position counter width default and fixed field widths
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned RATE_W         = 48;
  localparam int unsigned CPR_W          = 16;
  localparam int unsigned PERIOD_W       = 20;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 20;

  // Speed arithmetic: dividend = |delta| * 1e6 * 2^16, divisor = cpr * period_us
  localparam int unsigned     US_PER_S_W = 20;
  localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;
  localparam int unsigned     FRAC_BITS  = 16;
  localparam int unsigned     DEN_W      = CPR_W + PERIOD_W;
  localparam int unsigned     Q_W        = RATE_W + 1;

  localparam logic [RATE_W-1:0] RATE_SAT_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0] RATE_SAT_NEG = 48'h8000_0000_0000;

  // Register reset values
  localparam logic [CPR_W-1:0]    CPR_RESET    = 16'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPR_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPR_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US    = 3'd4;

  // x4 decode: index {previous AB, new AB}, step +1, -1 or 0
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  // Per-lane configuration
  typedef struct packed {
    logic                invert;
    logic [CPR_W-1:0]    cpr;
    logic [PERIOD_W-1:0] period_us;
  } lane_cfg_t;

  // Per-item control from the top level to each lane
  typedef struct packed {
    logic sample;
    logic tick;
    logic primed;
  } lane_ctrl_t;

  // Lane status back to the top level
  typedef struct packed {
    logic busy;
  } lane_stat_t;

endpackage

[src/dqds_lane.sv]
// One decoder lane: x4 step decode, wrapping position, tick delta and
// serial speed computation (shift-add multiply, restoring divide). Uses dqds_pkg.
module dqds_lane import dqds_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_cfg_t         cfg_i,
  input  lane_ctrl_t        ctrl_i,
  input  logic [1:0]        ab_i,
  output lane_stat_t        stat_o,
  output logic [OUT_W-1:0]  count_o,
  output logic [OUT_W-1:0]  delta_o,
  output logic [RATE_W-1:0] rate_o
);

  localparam int unsigned PROD_W    = COUNT_BITS + US_PER_S_W;
  localparam int unsigned NUM_W     = PROD_W + FRAC_BITS;
  localparam int unsigned MUL_CNT_W = $clog2(US_PER_S_W);
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(US_PER_S_W - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_MAG  = 5'b00010,
    L_MUL  = 5'b00100,
    L_DIV  = 5'b01000,
    L_FIN  = 5'b10000
  } lane_state_e;

  lane_state_e            state_q, state_d;
  logic [1:0]             prev_ab_q, prev_ab_d;
  logic [COUNT_BITS-1:0]  pos_q, pos_d;
  logic [COUNT_BITS-1:0]  last_q, last_d;
  logic [COUNT_BITS-1:0]  delta_q, delta_d;
  logic [RATE_W-1:0]      rate_q, rate_d;
  logic [MUL_CNT_W-1:0]   mul_cnt_q, mul_cnt_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                   neg_q, neg_d;
  logic [COUNT_BITS-1:0]  mag_q, mag_d;
  logic [DEN_W-1:0]       den_q, den_d;
  logic [PROD_W-1:0]      acc_q, acc_d;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [DEN_W-1:0]       rem_q, rem_d;
  logic [Q_W-1:0]         quo_q, quo_d;
  logic                   over_q, over_d;

  logic signed [1:0]      step;
  logic [CPR_W-1:0]       cpr_eff;
  logic [DEN_W:0]         rem_sh;
  logic                   rem_ge;
  logic [DEN_W:0]         rem_sub;
  logic [Q_W-1:0]         quo_sh;
  logic [RATE_W-1:0]      sat_lim;
  logic [RATE_W-1:0]      mag_rate;

  // Step decode and position update
  always_comb begin
    step = STEP_TABLE[{prev_ab_q, ab_i}];
    if (cfg_i.invert) begin
      step = -step;
    end
    pos_d     = pos_q;
    prev_ab_d = prev_ab_q;
    if (ctrl_i.sample) begin
      prev_ab_d = ab_i;
      if (ctrl_i.primed) begin
        pos_d = pos_q + {{(COUNT_BITS-2){step[1]}}, step};
      end
    end
  end

  // Division datapath
  assign cpr_eff = (cfg_i.cpr == '0) ? CPR_W'(1) : cfg_i.cpr;
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign quo_sh  = {quo_q[Q_W-2:0], rem_ge};

  // Saturation of the final quotient
  always_comb begin
    sat_lim = neg_q ? RATE_SAT_NEG : RATE_SAT_POS;
    if (over_q || (quo_q > {1'b0, sat_lim})) begin
      mag_rate = sat_lim;
    end else begin
      mag_rate = quo_q[RATE_W-1:0];
    end
  end

  // Speed sequencer
  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    delta_d   = delta_q;
    rate_d    = rate_q;
    mul_cnt_d = mul_cnt_q;
    div_cnt_d = div_cnt_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    den_d     = den_q;
    acc_d     = acc_q;
    num_d     = num_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    over_d    = over_q;
    unique case (state_q)
      L_IDLE: begin
        if (ctrl_i.tick) begin
          delta_d = pos_q - last_q;
          last_d  = pos_q;
          state_d = L_MAG;
        end
      end
      L_MAG: begin
        neg_d     = delta_q[COUNT_BITS-1];
        mag_d     = delta_q[COUNT_BITS-1] ? -delta_q : delta_q;
        den_d     = DEN_W'(cpr_eff) * DEN_W'(cfg_i.period_us);
        acc_d     = '0;
        rem_d     = '0;
        quo_d     = '0;
        over_d    = 1'b0;
        mul_cnt_d = MUL_LAST;
        state_d   = L_MUL;
      end
      L_MUL: begin
        // MSB-first shift-add by the constant 1e6
        acc_d = {acc_q[PROD_W-2:0], 1'b0} +
                (US_PER_S[mul_cnt_q] ? PROD_W'(mag_q) : '0);
        mul_cnt_d = mul_cnt_q - 1'b1;
        if (mul_cnt_q == '0) begin
          num_d     = {acc_d, {FRAC_BITS{1'b0}}};
          div_cnt_d = DIV_LAST;
          state_d   = L_DIV;
        end
      end
      L_DIV: begin
        // one quotient bit per cycle; sticky flag once past the negative limit
        rem_d     = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_d     = quo_sh;
        over_d    = over_q | (quo_sh > {1'b0, RATE_SAT_NEG});
        num_d     = {num_q[NUM_W-2:0], 1'b0};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d = L_FIN;
        end
      end
      L_FIN: begin
        rate_d  = neg_q ? -mag_rate : mag_rate;
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= L_IDLE;
      prev_ab_q <= '0;
      pos_q     <= '0;
      last_q    <= '0;
      delta_q   <= '0;
      rate_q    <= '0;
      mul_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      prev_ab_q <= prev_ab_d;
      pos_q     <= pos_d;
      last_q    <= last_d;
      delta_q   <= delta_d;
      rate_q    <= rate_d;
      mul_cnt_q <= mul_cnt_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // Arithmetic working registers
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    den_q  <= den_d;
    acc_q  <= acc_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    over_q <= over_d;
  end

  // Position and delta as 32-bit results
  generate
    if (COUNT_BITS >= OUT_W) begin : g_trunc
      assign count_o = pos_d[OUT_W-1:0];
      assign delta_o = delta_q[OUT_W-1:0];
    end else begin : g_sext
      assign count_o = {{(OUT_W-COUNT_BITS){pos_d[COUNT_BITS-1]}}, pos_d};
      assign delta_o = {{(OUT_W-COUNT_BITS){delta_q[COUNT_BITS-1]}}, delta_q};
    end
  endgenerate

  assign rate_o      = rate_q;
  assign stat_o.busy = (state_q != L_IDLE);

endmodule

[src/dual_quadrature_decoder_speed.sv]
// Top level of the dual quadrature decoder with speed estimate.
// Instantiates two dqds_lane decoders and merges their results into one
// output register. Uses dqds_pkg.
//
// Usage:
//   Input stream: tuser = 0 is a pin sample (tdata bits 0..3 = left A, left B,
//   right A, right B), tuser = 1 is a speed tick. Every item gives exactly one
//   result item carrying both counts, the last latched deltas and speeds,
//   with tuser set when the item was a tick that latched new values.
//   Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i;
//   0/1 invert left/right, 2/3 counts per revolution, 4 period in us.
//   A sample, or a tick while period_us is zero, shows its result in the cycle
//   after acceptance; one such item is taken every cycle while the receiver keeps up.
//   A tick that latches runs both lanes side by side: a 20-step shift-add multiply
//   and a one-bit-a-cycle restoring divide of COUNT_BITS + 36 steps; tready stays
//   low meanwhile.
//   The first sample after reset only loads the previous pin states.
//   Reset clears positions, deltas, speeds and registers to their defaults.
//   A stalled receiver holds the result; a new item is still taken in the
//   cycle the waiting result leaves.
module dual_quadrature_decoder_speed import dqds_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // left_a, left_b, right_a, right_b, 4'b0
  input  logic                  s_axis_tuser_i,   // req_type
  // Result items
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [223:0]          m_axis_tdata_o,   // left_count, right_count, left_delta,
                                                  // right_delta, left_speed, right_speed
  output logic                  m_axis_tuser_o,   // speed_valid
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_WAIT = 2'b10
  } top_state_e;

  top_state_e          state_q, state_d;
  logic                primed_q;
  logic                inv_l_q, inv_r_q;
  logic [CPR_W-1:0]    cpr_l_q, cpr_r_q;
  logic [PERIOD_W-1:0] period_q;

  logic                out_valid_q, out_valid_d;
  logic [223:0]        out_data_q;
  logic                out_user_q;

  logic                accept;
  logic                tick_go;
  logic                sample_go;
  logic                load_now;
  logic                lanes_idle;

  lane_cfg_t           cfg_l, cfg_r;
  lane_ctrl_t          ctrl;
  lane_stat_t          stat_l, stat_r;
  logic [OUT_W-1:0]    count_l, count_r, delta_l, delta_r;
  logic [RATE_W-1:0]   rate_l, rate_r;

  // Handshake and item decode
  assign s_axis_tready_o = (state_q == T_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign tick_go         = accept && s_axis_tuser_i && (period_q != '0);
  assign sample_go       = accept && !s_axis_tuser_i;
  assign lanes_idle      = !stat_l.busy && !stat_r.busy;
  assign load_now        = (accept && !tick_go) || ((state_q == T_WAIT) && lanes_idle);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_l_q  <= 1'b0;
      inv_r_q  <= 1'b0;
      cpr_l_q  <= CPR_RESET;
      cpr_r_q  <= CPR_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INVERT_LEFT:  inv_l_q  <= cfg_data_i[0];
        REG_INVERT_RIGHT: inv_r_q  <= cfg_data_i[0];
        REG_CPR_LEFT:     cpr_l_q  <= cfg_data_i[CPR_W-1:0];
        REG_CPR_RIGHT:    cpr_r_q  <= cfg_data_i[CPR_W-1:0];
        REG_PERIOD_US:    period_q <= cfg_data_i[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lanes
  assign cfg_l       = '{invert: inv_l_q, cpr: cpr_l_q, period_us: period_q};
  assign cfg_r       = '{invert: inv_r_q, cpr: cpr_r_q, period_us: period_q};
  assign ctrl.sample = sample_go;
  assign ctrl.tick   = tick_go;
  assign ctrl.primed = primed_q;

  dqds_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_l),
    .ctrl_i  (ctrl),
    .ab_i    ({s_axis_tdata_i[0], s_axis_tdata_i[1]}),
    .stat_o  (stat_l),
    .count_o (count_l),
    .delta_o (delta_l),
    .rate_o  (rate_l)
  );

  dqds_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_r),
    .ctrl_i  (ctrl),
    .ab_i    ({s_axis_tdata_i[2], s_axis_tdata_i[3]}),
    .stat_o  (stat_r),
    .count_o (count_r),
    .delta_o (delta_r),
    .rate_o  (rate_r)
  );

  // Tick sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (tick_go) state_d = T_WAIT;
      T_WAIT: if (lanes_idle) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_now) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (sample_go) begin
        primed_q <= 1'b1;
      end
    end
  end

  // Merge both lanes into the result item
  always_ff @(posedge clk_i) begin
    if (load_now) begin
      out_data_q <= {rate_r, rate_l, delta_r, delta_l, count_r, count_l};
      out_user_q <= (state_q == T_WAIT);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

[src/dqds_checker.sv]
// Port-level checks for dual_quadrature_decoder_speed, bound to the top level.
// Uses only the top level's ports; no package dependency.
module dqds_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [223:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  // A sample gives its result in the next cycle, without the speed flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=>
      m_axis_tvalid_o && !m_axis_tuser_o)
    else $error("sample result missing or flagged as speed");

  // An input item is only taken when the output slot is free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tready_i)
    else $error("input taken while result stalled");

endmodule

bind dual_quadrature_decoder_speed dqds_checker u_dqds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
